// File: hw/rtl/sliding_minute_rate_counter_assert.svh
// Assertion macros shared by the rate counter's checker.
// No dependencies; include by bare file name.
`ifndef SLIDING_MINUTE_RATE_COUNTER_ASSERT_SVH
`define SLIDING_MINUTE_RATE_COUNTER_ASSERT_SVH

// Cause and effect in the same cycle.
`define SMRC_ASSERT_NOW(label, clk, rst, cause, effect, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cause) |-> (effect)) \
      else $error(msg);

// Effect in the cycle after the cause.
`define SMRC_ASSERT_NEXT(label, clk, rst, cause, effect, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) \
      else $error(msg);

`endif

// File: hw/rtl/smrc_pkg.sv
// Shared types, constants and the sequencer control store for the rate counter.
// No dependencies.
package smrc_pkg;

   localparam int BUCKETS_DEF = 60;
   localparam int SECOND_CODES = 64;
   localparam logic [6:0] MINUTE_AT_RESET = 7'd61;
   localparam logic [62:0] TOTAL_MAX = {63{1'b1}};
   localparam logic [31:0] PENDING_MAX = 32'hFFFF_FFFF;
   localparam logic [30:0] RATE_MAX = {31{1'b1}};

   typedef struct packed {
      logic signed [63:0] increment;
      logic [5:0]         now_second;
      logic [5:0]         now_minute;
   } req_type;

   typedef struct packed {
      logic [62:0] running_total;
      logic [30:0] window_rate;
   } rsp_type;

   // Program steps
   typedef enum logic [1:0] {
      STEP_IDLE,
      STEP_PREP,
      STEP_SWEEP,
      STEP_EMIT
   } step_type;

   // Jump conditions
   typedef enum logic [1:0] {
      COND_ALWAYS,
      COND_REQ,
      COND_LAST,
      COND_OUT_FREE
   } cond_type;

   // One control word: jump condition, both targets, datapath strobes
   typedef struct packed {
      cond_type cond;
      step_type next_hit;
      step_type next_miss;
      logic     take;
      logic     prep;
      logic     sweep;
      logic     emit;
   } ucode_type;

   // What the bucket sweep does to each entry
   typedef struct packed {
      logic clear_all;
      logic changed;
      logic wrap;
   } sweep_flags_type;

   // Control store
   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type w;
      case (step)
         STEP_IDLE:  w = '{COND_REQ,      STEP_PREP,  STEP_IDLE,  1'b1, 1'b0, 1'b0, 1'b0};
         STEP_PREP:  w = '{COND_ALWAYS,   STEP_SWEEP, STEP_SWEEP, 1'b0, 1'b1, 1'b0, 1'b0};
         STEP_SWEEP: w = '{COND_LAST,     STEP_EMIT,  STEP_SWEEP, 1'b0, 1'b0, 1'b1, 1'b0};
         STEP_EMIT:  w = '{COND_OUT_FREE, STEP_IDLE,  STEP_EMIT,  1'b0, 1'b0, 1'b0, 1'b1};
         default:    w = '{COND_ALWAYS,   STEP_IDLE,  STEP_IDLE,  1'b0, 1'b0, 1'b0, 1'b0};
      endcase
      return w;
   endfunction

endpackage

// File: hw/rtl/smrc_window.sv
// Second-bucket memory with the per-event sweep: clear, store, and sum.
// Depends on smrc_pkg.
module smrc_window import smrc_pkg::*; #(
   parameter int   BUCKETS = BUCKETS_DEF,
   localparam int  SEC_W   = $clog2(BUCKETS)
) (
   input  logic             clock,
   input  logic             reset,
   input  ucode_type        uc,
   input  sweep_flags_type  flags,
   input  logic [SEC_W-1:0] sec,
   input  logic [SEC_W-1:0] from,
   input  logic [31:0]      wr_val,
   output logic             sweep_last,
   output logic [30:0]      window_sum
);

   localparam logic [SEC_W-1:0] LAST_IDX = SEC_W'(BUCKETS - 1);

   logic [31:0]      mem [BUCKETS];
   logic [31:0]      rd_data_ff;
   logic [SEC_W-1:0] rd_addr;
   logic [SEC_W-1:0] idx_ff, idx_in;
   logic [30:0]      acc_ff, acc_in;
   logic             live_ff, live_in;
   logic [31:0]      old_val, new_val;
   logic             in_skip;
   logic [32:0]      sum_wide;

   assign sweep_last = (idx_ff == LAST_IDX);
   assign window_sum = acc_ff;

   // Next read runs one entry ahead of the write
   assign rd_addr = (uc.sweep && !sweep_last) ? idx_ff + 1'b1 : '0;

   // Memory holds garbage until the first sweep has written every entry
   assign old_val = live_ff ? rd_data_ff : '0;

   // Skipped seconds lie strictly between the old and the new second
   assign in_skip = flags.wrap ? (idx_ff > from || idx_ff < sec)
                               : (idx_ff > from && idx_ff < sec);

   always_comb begin
      if (flags.changed && idx_ff == sec) begin
         new_val = wr_val;
      end else if (flags.clear_all || (flags.changed && in_skip)) begin
         new_val = '0;
      end else begin
         new_val = old_val;
      end
   end

   // Saturating running sum
   assign sum_wide = {2'b00, acc_ff} + {1'b0, new_val};

   always_comb begin
      idx_in  = idx_ff;
      acc_in  = acc_ff;
      live_in = live_ff;
      if (uc.prep) begin
         idx_in = '0;
         acc_in = '0;
      end else if (uc.sweep) begin
         acc_in = (sum_wide > {2'b00, RATE_MAX}) ? RATE_MAX : sum_wide[30:0];
         if (sweep_last) begin
            live_in = 1'b1;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= '0;
         acc_ff  <= '0;
         live_ff <= 1'b0;
      end else begin
         idx_ff  <= idx_in;
         acc_ff  <= acc_in;
         live_ff <= live_in;
      end
   end

   // Bucket memory: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (uc.sweep) begin
         mem[idx_ff] <= new_val;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule

// File: hw/rtl/sliding_minute_rate_counter.sv
// Sliding one-minute hit counter: sequencer, running total and time tracking.
// Depends on smrc_pkg and smrc_window.
// Usage:
//   req channel carries one event beat: a signed increment plus the current
//   second and minute. A positive increment adds to the saturating running
//   total and to the count pending for the current second.
//   rsp channel returns one beat per event: the running total and the
//   saturating sum of all second buckets.
// Timing:
//   After a req beat is accepted, rsp_valid rises once the prep, sweep and emit
//   steps are through; emit waits while an earlier result is stalled. A new req
//   beat is taken only after the emit step. The pace comes from the bucket sweep,
//   which visits every bucket in turn, one per cycle, with one write and one read.
//   req_stall is low only while the sequencer waits for an event.
// Reset:
//   Synchronous, active high. Buckets read as zero, total and pending are zero,
//   last minute is 61. No clearing pass: memory goes live after the first sweep.
// Backpressure:
//   The result sits in an output register; the next event is accepted while
//   it waits. A second result waits in the emit step until rsp_stall drops.
module sliding_minute_rate_counter import smrc_pkg::*; #(
   parameter int BUCKETS = BUCKETS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int SEC_W = $clog2(BUCKETS);

   step_type        step_ff, step_in;
   ucode_type       uc;
   logic            cond_hit;
   logic            out_free;
   logic            req_take;

   req_type         req_ff;
   logic [62:0]     total_ff;
   logic [31:0]     pending_ff;
   logic [SEC_W-1:0] last_sec_ff;
   logic [6:0]      last_min_ff;

   logic [SEC_W-1:0] sec_ff, from_ff;
   logic [31:0]     wr_val_ff;
   sweep_flags_type flags_ff;

   logic            rsp_valid_ff;
   rsp_type         rsp_data_ff;

   logic            sweep_last;
   logic [30:0]     window_sum;

   logic [SEC_W-1:0] sec_lut [SECOND_CODES];
   logic            inc_pos;
   logic [63:0]     total_sum, pend_sum;
   logic [62:0]     total_new;
   logic [31:0]     pend_new;
   logic [SEC_W-1:0] sec_now;
   logic [7:0]      min_diff;
   logic            clear_all, changed, wrap;

   // Second code to bucket index
   for (genvar g = 0; g < SECOND_CODES; g++) begin : g_sec_lut
      assign sec_lut[g] = SEC_W'(g % BUCKETS);
   end

   // Sequencer: step counter walks the control store
   assign uc = ucode_rom(step_ff);

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !uc.take;
   assign req_take  = req_valid && uc.take;

   always_comb begin
      case (uc.cond)
         COND_ALWAYS:   cond_hit = 1'b1;
         COND_REQ:      cond_hit = req_valid;
         COND_LAST:     cond_hit = sweep_last;
         COND_OUT_FREE: cond_hit = out_free;
         default:       cond_hit = 1'b1;
      endcase
      step_in = cond_hit ? uc.next_hit : uc.next_miss;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   // Capture the event beat
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_data;
      end
   end

   // Saturating total and pending count
   assign inc_pos   = !req_ff.increment[63] && (req_ff.increment != '0);
   assign total_sum = {1'b0, total_ff} + {1'b0, req_ff.increment[62:0]};
   assign pend_sum  = {32'b0, pending_ff} + {1'b0, req_ff.increment[62:0]};
   assign total_new = !inc_pos ? total_ff
                    : (total_sum[63] ? TOTAL_MAX : total_sum[62:0]);
   assign pend_new  = !inc_pos ? pending_ff
                    : ((pend_sum >= {32'b0, PENDING_MAX}) ? PENDING_MAX : pend_sum[31:0]);

   // Time compare against the last change of second
   assign sec_now   = sec_lut[req_ff.now_second];
   assign min_diff  = {2'b00, req_ff.now_minute} - {1'b0, last_min_ff};
   assign clear_all = $signed(min_diff) > 8'sd1;
   assign changed   = (sec_now != last_sec_ff);
   assign wrap      = (sec_now < last_sec_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff    <= '0;
         pending_ff  <= '0;
         last_sec_ff <= '0;
         last_min_ff <= MINUTE_AT_RESET;
      end else if (uc.prep) begin
         total_ff <= total_new;
         if (changed) begin
            pending_ff  <= '0;
            last_sec_ff <= sec_now;
            last_min_ff <= {1'b0, req_ff.now_minute};
         end else begin
            pending_ff <= pend_new;
         end
      end
   end

   // Sweep command, held steady through the sweep
   always_ff @(posedge clock) begin
      if (uc.prep) begin
         sec_ff    <= sec_now;
         from_ff   <= last_sec_ff;
         wr_val_ff <= pend_new;
         flags_ff  <= '{clear_all: clear_all, changed: changed, wrap: wrap};
      end
   end

   smrc_window #(
      .BUCKETS (BUCKETS)
   ) u_window (
      .clock      (clock),
      .reset      (reset),
      .uc         (uc),
      .flags      (flags_ff),
      .sec        (sec_ff),
      .from       (from_ff),
      .wr_val     (wr_val_ff),
      .sweep_last (sweep_last),
      .window_sum (window_sum)
   );

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (uc.emit && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (uc.emit && out_free) begin
         rsp_data_ff <= '{running_total: total_ff, window_rate: window_sum};
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: hw/rtl/smrc_checker.sv
// Port-level checks for the rate counter, bound onto the top level.
// Depends on smrc_pkg and sliding_minute_rate_counter_assert.svh.
`include "sliding_minute_rate_counter_assert.svh"

module smrc_checker import smrc_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   logic rsp_held;
   logic req_took;

   assign rsp_held = rsp_valid && rsp_stall;
   assign req_took = req_valid && !req_stall;

   // Stalled result beat stays put
   `SMRC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid, "rsp beat dropped")
   `SMRC_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_held, $stable(rsp_data), "rsp data moved")

   // One event at a time: busy right after a beat is taken
   `SMRC_ASSERT_NEXT(a_req_busy, clock, reset, req_took, req_stall, "req taken twice in a row")

   // A result never appears the cycle after an event is taken
   `SMRC_ASSERT_NEXT(a_rsp_latency, clock, reset, req_took, !$rose(rsp_valid), "rsp too early")

   // Ready for an event right out of reset
   `SMRC_ASSERT_NOW(a_reset_idle, clock, reset, $past(reset), !req_stall, "not idle after reset")

endmodule

bind sliding_minute_rate_counter smrc_checker u_smrc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// File: tb/sv/sliding_minute_rate_counter_checker.sv
`timescale 1ns / 100ps
// Checker for the sliding minute rate counter: watches the req and rsp channels,
// keeps a shadow of the buckets, totals and time, and compares every rsp beat.
// Depends on smrc_pkg.
module sliding_minute_rate_counter_checker import smrc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      awaiting,
   output int      checked_count,
   output int      window_caps
);

   localparam int          SECONDS      = BUCKETS_DEF;
   localparam logic [63:0] TOTAL_CEIL   = {1'b0, TOTAL_MAX};
   localparam logic [63:0] PENDING_CEIL = {32'd0, PENDING_MAX};
   localparam logic [63:0] RATE_CEIL    = {33'd0, RATE_MAX};

   // Shadow state of the counter
   logic [31:0] shadow_buckets [SECONDS];
   logic [31:0] shadow_pending;
   int          shadow_second;
   int          shadow_minute;
   logic [63:0] shadow_total;

   // Answers owed by the block, oldest first
   rsp_type     due_rates [$];
   int          mismatches = 0;
   int          checked    = 0;
   int          capped     = 0;

   function automatic void wipe_window();
      for (int i = 0; i < SECONDS; i++)
         shadow_buckets[i] = '0;
   endfunction

   // Apply one event to the shadow state and return the answer it owes
   function automatic rsp_type tally_event(input req_type ev);
      logic [63:0] hits;
      logic [63:0] window;
      int          sec;
      int          minute;
      rsp_type     res;
      hits   = ev.increment;
      sec    = int'(ev.now_second) % SECONDS;
      minute = int'(ev.now_minute);
      // positive hits feed the total and the current second, both saturating
      if (!hits[63] && hits != '0) begin
         if (hits > TOTAL_CEIL - shadow_total)
            shadow_total = TOTAL_CEIL;
         else
            shadow_total = shadow_total + hits;
         if (hits >= PENDING_CEIL - {32'd0, shadow_pending})
            shadow_pending = PENDING_MAX;
         else
            shadow_pending = shadow_pending + hits[31:0];
      end
      // forward jump of more than one minute empties the window
      if (minute - shadow_minute > 1)
         wipe_window();
      // new second: drop skipped seconds (with wrap), then bank the pending count
      if (sec != shadow_second) begin
         for (int i = 0; i < SECONDS; i++) begin
            if (sec < shadow_second ? (i > shadow_second || i < sec)
                                    : (i > shadow_second && i < sec))
               shadow_buckets[i] = '0;
         end
         shadow_buckets[sec] = shadow_pending;
         shadow_pending      = '0;
         shadow_second       = sec;
         shadow_minute       = minute;
      end
      // window sum, capped
      window = '0;
      for (int i = 0; i < SECONDS && window <= RATE_CEIL; i++)
         window = window + shadow_buckets[i];
      if (window > RATE_CEIL)
         window = RATE_CEIL;
      res.running_total = shadow_total[62:0];
      res.window_rate   = window[30:0];
      return res;
   endfunction

   // Sample both channels at the edge; response side first so the owed order holds
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         wipe_window();
         shadow_pending = '0;
         shadow_second  = 0;
         shadow_minute  = int'(MINUTE_AT_RESET);
         shadow_total   = '0;
         due_rates.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_rates.size() == 0) begin
               $display("%0t: unexpected rsp beat: expected none, got total %h rate %h",
                        $time, rsp_data.running_total, rsp_data.window_rate);
               mismatches++;
            end else begin
               want = due_rates.pop_front();
               checked++;
               if (rsp_data.running_total !== want.running_total) begin
                  $display("%0t: running_total expected %h, got %h",
                           $time, want.running_total, rsp_data.running_total);
                  mismatches++;
               end
               if (rsp_data.window_rate !== want.window_rate) begin
                  $display("%0t: window_rate expected %h, got %h",
                           $time, want.window_rate, rsp_data.window_rate);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            want = tally_event(req_data);
            if (want.window_rate == RATE_MAX)
               capped++;
            due_rates.push_back(want);
         end
      end
      fail_count    <= mismatches;
      awaiting      <= due_rates.size();
      checked_count <= checked;
      window_caps   <= capped;
   end

endmodule

// File: tb/sv/sliding_minute_rate_counter_tb.sv
`timescale 1ns / 100ps
// Top of the rate counter testbench: clock, reset, event stimulus and rsp stalls.
// Depends on smrc_pkg, sliding_minute_rate_counter and its checker.
module sliding_minute_rate_counter_tb;
   import smrc_pkg::*;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   req_type req_data  = '0;
   logic    req_stall;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   int      fail_count;
   int      awaiting;
   int      checked_count;
   int      window_caps;

   bit      quiet       = 1'b0;   // no gaps and no stalls while set
   int      events_sent = 0;
   int      wall_second = 0;      // clock of the well-formed event stream
   int      wall_minute = 0;

   always #4 clock = ~clock;

   sliding_minute_rate_counter u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   sliding_minute_rate_counter_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .awaiting      (awaiting),
      .checked_count (checked_count),
      .window_caps   (window_caps)
   );

   // Idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet)
         return 0;
      if (roll < 55)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 4);
      if (roll < 97)
         return $urandom_range(5, 30);
      return $urandom_range(60, 150);
   endfunction

   function automatic req_type make_event(input logic [63:0] hits, input int sec,
                                          input int minute);
      req_type ev;
      ev.increment  = hits;
      ev.now_second = sec[5:0];
      ev.now_minute = minute[5:0];
      return ev;
   endfunction

   // Mostly a clock moving forward with random hits; a few beats of pure noise
   function automatic req_type next_random_event();
      logic [63:0] hits;
      int          roll;
      int          step;
      int          stamp;
      roll = $urandom_range(0, 99);
      if (roll < 50)
         hits = 64'($urandom_range(1, 20));
      else if (roll < 62)
         hits = '0;
      else if (roll < 72)
         hits = {1'b1, 31'($urandom), $urandom};
      else if (roll < 82)
         hits = {40'd0, 24'($urandom)};
      else if (roll < 87)
         hits = {32'd0, $urandom};
      else if (roll < 94)
         hits = {24'd0, 8'($urandom), $urandom};
      else
         hits = 64'h0000_0000_FFFF_FFFF - 64'($urandom_range(0, 16));
      roll = $urandom_range(0, 99);
      if (roll < 6)
         return make_event(hits, $urandom_range(0, 63), $urandom_range(0, 63));
      if (roll < 40)
         step = 0;
      else if (roll < 75)
         step = 1;
      else if (roll < 90)
         step = $urandom_range(2, 10);
      else if (roll < 97)
         step = $urandom_range(11, 59);
      else
         step = $urandom_range(60, 300);
      stamp       = (wall_minute * 60 + wall_second + step) % 3600;
      wall_minute = stamp / 60;
      wall_second = stamp % 60;
      return make_event(hits, wall_second, wall_minute);
   endfunction

   // One req beat, after an optional gap; valid stays up until taken
   task automatic send_event(input req_type ev);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data  <= ev;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      events_sent++;
   endtask

   // Hold the sender until every owed answer has come back
   task automatic drain_events();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaiting != 0) @(posedge clock);
   endtask

   // Response side: random stall stretches, none while quiet
   initial begin
      int hold;
      @(posedge clock);
      forever begin
         if (quiet) begin
            rsp_stall <= 1'b0;
            hold = 8;
         end else begin
            rsp_stall <= ($urandom_range(0, 2) == 0);
            hold = pick_gap() + 1;
         end
         repeat (hold) @(posedge clock);
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // minute 63 against the reset minute clears, 62 does not
      send_event(make_event(64'd3, 0, 63));
      send_event(make_event(64'd4, 0, 62));
      send_event(make_event(64'd0, 1, 0));
      // queries: minus one and the most negative increment
      send_event(make_event(64'hFFFF_FFFF_FFFF_FFFF, 1, 0));
      send_event(make_event(64'h8000_0000_0000_0000, 1, 0));
      // pending count saturates, then lands in a bucket and caps the window
      send_event(make_event(64'd10, 1, 0));
      send_event(make_event(64'h0000_0001_0000_0005, 1, 0));
      send_event(make_event(64'd1, 2, 0));
      send_event(make_event(64'd6, 5, 0));
      // seconds past 59 fold back, with wrap of the skipped range
      send_event(make_event(64'd1, 60, 0));
      send_event(make_event(64'd2, 63, 0));
      send_event(make_event(64'd1, 59, 1));
      // two-minute jump across the wrap, then a long jump
      send_event(make_event(64'd1, 2, 3));
      send_event(make_event(64'd1, 30, 59));
      // hour wrap keeps the window
      send_event(make_event(64'd1, 31, 0));
      // same second: the minute is not taken, so each of these clears
      send_event(make_event(64'd1, 31, 5));
      send_event(make_event(64'd1, 31, 6));
      send_event(make_event(64'd7, 61, 62));
      send_event(make_event(64'd7, 2, 63));
      send_event(make_event(64'h0000_0000_7FFF_FFFF, 2, 63));
      send_event(make_event(64'h0000_0000_8000_0000, 3, 63));
      send_event(make_event(64'd0, 4, 63));
      drain_events();

      wall_second = 4;
      wall_minute = 0;
      for (int n = 0; n < 1620; n++) begin
         quiet = (n >= 300 && n < 450);
         if (n == 800)
            drain_events();
         send_event(next_random_event());
      end

      // total saturation last, since it sticks for the rest of the run
      send_event(make_event(64'h7FFF_FFFF_FFFF_FFFF, wall_second, wall_minute));
      send_event(make_event(64'h4000_0000_0000_0000, wall_second, wall_minute));
      send_event(make_event(64'd9, (wall_second + 1) % 60, wall_minute));
      send_event(make_event(64'hFFFF_FFFF_FFFF_FFFB, (wall_second + 2) % 60, wall_minute));

      drain_events();
      repeat (80) @(posedge clock);
      $display("Run covered %0d events and %0d checked answers, %0d with a capped window.",
               events_sent, checked_count, window_caps);
      if (fail_count == 0)
         $display("sliding_minute_rate_counter: match");
      else
         $display("sliding_minute_rate_counter: mismatch");
      $finish;
   end

   // Run limit
   initial begin
      #25_000_000;
      $display("sliding_minute_rate_counter: mismatch");
      $finish;
   end

endmodule
